>>> design/psll_pkg.sv
// shared types and constants for the pooled singly linked list
`default_nettype none

package psll_pkg;

  // pool geometry and field widths
  localparam int POOL_SLOTS   = 16;
  localparam int ELEMENT_BITS = 32;
  localparam int SLOT_BITS    = $clog2(POOL_SLOTS);
  localparam int LINK_BITS    = $clog2(POOL_SLOTS + 1);
  localparam int COUNT_BITS   = 5;
  localparam int MODE_BITS    = 3;
  localparam int STATUS_BITS  = 3;

  localparam logic [LINK_BITS-1:0]  NULL_LINK = LINK_BITS'(POOL_SLOTS);
  localparam logic [COUNT_BITS-1:0] CAP_RESET = COUNT_BITS'(16);

  // operation codes
  localparam logic [MODE_BITS-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ERASE  = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_READ   = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 3'd5;

  // status codes
  localparam logic [STATUS_BITS-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd1;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY     = 3'd2;
  localparam logic [STATUS_BITS-1:0] STAT_NULL_ELEM = 3'd3;
  localparam logic [STATUS_BITS-1:0] STAT_NO_NEXT   = 3'd4;

  // request payload
  typedef struct packed {
    logic [MODE_BITS-1:0]    mode;
    logic                    node_given;
    logic [SLOT_BITS-1:0]    node_slot;
    logic [ELEMENT_BITS-1:0] element_value;
  } psll_in_t;

  // result payload
  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic [SLOT_BITS-1:0]    result_slot;
    logic [ELEMENT_BITS-1:0] result_element;
    logic                    head_valid;
    logic [SLOT_BITS-1:0]    head_slot;
    logic [COUNT_BITS-1:0]   node_count;
  } psll_out_t;

  // controller to datapath step strobes
  typedef struct packed {
    logic accept;
    logic exec;
    logic link_rd;
    logic wr2;
    logic walk_rd;
    logic walk_wr;
    logic load_out;
  } psll_cmd_t;

  // datapath to controller flow decisions
  typedef struct packed {
    logic to_link_rd;
    logic to_wr2;
    logic to_walk;
    logic walk_more;
  } psll_flow_t;

endpackage

`default_nettype wire

>>> design/psll_ctrl.sv
// sequencing state machine and handshake control for the list core
`default_nettype none

module psll_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  psll_pkg::psll_flow_t   flow,
  output psll_pkg::psll_cmd_t    cmd
);
  import psll_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_EXEC    = 7'b0000010,
    S_LINK_RD = 7'b0000100,
    S_WR2     = 7'b0001000,
    S_WALK_WR = 7'b0010000,
    S_WALK_RD = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  // output slot can take a result this cycle
  assign out_free = !out_valid || out_ready;

  // handshake and step strobes
  assign in_ready     = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.link_rd  = (state == S_LINK_RD);
  assign cmd.wr2      = (state == S_WR2);
  assign cmd.walk_rd  = (state == S_WALK_RD);
  assign cmd.walk_wr  = (state == S_WALK_WR);
  assign cmd.load_out = (state == S_DONE) && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (flow.to_link_rd)  state_next = S_LINK_RD;
        else if (flow.to_wr2) state_next = S_WR2;
        else if (flow.to_walk) state_next = S_WALK_WR;
        else                  state_next = S_DONE;
      end
      S_LINK_RD: state_next = S_WR2;
      S_WR2:     state_next = S_DONE;
      S_WALK_WR: begin
        state_next = flow.walk_more ? S_WALK_RD : S_DONE;
      end
      S_WALK_RD: state_next = S_WALK_WR;
      S_DONE: begin
        if (out_free) state_next = cmd.accept ? S_EXEC : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a loaded result shows up next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  // an accepted request always starts execution next
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_EXEC))
    else $error("accepted request did not enter execution");

  // dependent link read is always followed by the second write
  a_link_then_wr2: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK_RD) |=> (state == S_WR2))
    else $error("link read step not followed by second write");

  // walk read alternates with walk write
  a_walk_alt: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_RD) |=> (state == S_WALK_WR))
    else $error("walk read step not followed by walk write");

endmodule

`default_nettype wire

>>> design/psll_datapath.sv
// link and element memories, list registers and result register
`default_nettype none

module psll_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  psll_pkg::psll_cmd_t               cmd,
  output psll_pkg::psll_flow_t              flow,
  input  psll_pkg::psll_in_t                in_data,
  input  logic                              cfg_we,
  input  logic [psll_pkg::COUNT_BITS-1:0]   cfg_data,
  output psll_pkg::psll_out_t               out_data
);
  import psll_pkg::*;

  // memories
  logic [LINK_BITS-1:0]    link_mem [POOL_SLOTS];
  logic [ELEMENT_BITS-1:0] elem_mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0]   link_vld;

  // list state
  logic [LINK_BITS-1:0]  list_head, free_head, cur;
  logic [COUNT_BITS-1:0] list_count, capacity, walk_n;
  psll_in_t              req;

  // registered read ports
  logic [LINK_BITS-1:0]    link_a_raw, link_b_raw, link_a, link_b;
  logic                    link_a_hit, link_b_hit;
  logic [SLOT_BITS-1:0]    link_a_addr, link_b_addr;
  logic [ELEMENT_BITS-1:0] elem_rd;

  // pending second link write
  logic [SLOT_BITS-1:0] pw_addr;
  logic [LINK_BITS-1:0] pw_data;
  logic                 pw_free;

  // result fields held until the output register loads
  logic [STATUS_BITS-1:0]  res_status;
  logic [SLOT_BITS-1:0]    res_slot;
  logic [ELEMENT_BITS-1:0] res_elem;

  // decode
  logic head_null, free_null, cnt_zero, full, elem_zero, t_null;
  logic do_push, do_pop, do_ins, do_era, do_read, do_clear, era_go;
  logic [STATUS_BITS-1:0] stat;

  // port controls
  logic                    rd_a_en;
  logic [SLOT_BITS-1:0]    rd_a_addr, elem_rd_addr;
  logic                    wr_en, elem_we;
  logic [SLOT_BITS-1:0]    wr_addr;
  logic [LINK_BITS-1:0]    wr_data;

  // unwritten links read as their reset chain value
  assign link_a = link_a_hit ? link_a_raw : LINK_BITS'(link_a_addr) + LINK_BITS'(1);
  assign link_b = link_b_hit ? link_b_raw : LINK_BITS'(link_b_addr) + LINK_BITS'(1);

  // list conditions
  assign head_null = (list_head == NULL_LINK);
  assign free_null = (free_head == NULL_LINK);
  assign cnt_zero  = (list_count == '0);
  assign full      = (list_count >= capacity) || free_null;
  assign elem_zero = (req.element_value == '0);
  assign t_null    = (link_a == NULL_LINK);
  assign era_go    = do_era && !t_null;

  // operation decode and status
  always_comb begin
    do_push  = 1'b0;
    do_pop   = 1'b0;
    do_ins   = 1'b0;
    do_era   = 1'b0;
    do_read  = 1'b0;
    do_clear = 1'b0;
    stat     = STAT_OK;
    case (req.mode)
      MODE_PUSH: begin
        if (full) stat = STAT_FULL;
        else      do_push = 1'b1;
      end
      MODE_POP: begin
        if (cnt_zero || head_null) stat = STAT_EMPTY;
        else                       do_pop = 1'b1;
      end
      MODE_INSERT: begin
        if (elem_zero)            stat = STAT_NULL_ELEM;
        else if (full)            stat = STAT_FULL;
        else if (!req.node_given) do_push = 1'b1;
        else                      do_ins = 1'b1;
      end
      MODE_ERASE: begin
        if (cnt_zero)             stat = STAT_EMPTY;
        else if (req.node_given)  do_era = 1'b1;
        else if (head_null)       stat = STAT_EMPTY;
        else                      do_pop = 1'b1;
      end
      MODE_READ: begin
        if (!req.node_given || cnt_zero) stat = STAT_EMPTY;
        else                             do_read = 1'b1;
      end
      MODE_CLEAR: do_clear = 1'b1;
      default: stat = STAT_OK;
    endcase
  end

  // flow back to the controller
  assign flow.to_link_rd = era_go;
  assign flow.to_wr2     = do_ins;
  assign flow.to_walk    = do_clear;
  assign flow.walk_more  = (cur != NULL_LINK) && (walk_n < list_count);

  // link read port a address select
  always_comb begin
    rd_a_en   = 1'b0;
    rd_a_addr = list_head[SLOT_BITS-1:0];
    if (cmd.accept) begin
      rd_a_en = 1'b1;
      case (in_data.mode)
        MODE_PUSH, MODE_INSERT: rd_a_addr = free_head[SLOT_BITS-1:0];
        MODE_ERASE: begin
          rd_a_addr = in_data.node_given ? in_data.node_slot : list_head[SLOT_BITS-1:0];
        end
        default: rd_a_addr = list_head[SLOT_BITS-1:0];
      endcase
    end else if (cmd.exec && era_go) begin
      rd_a_en   = 1'b1;
      rd_a_addr = link_a[SLOT_BITS-1:0];
    end else if (cmd.walk_rd) begin
      rd_a_en   = 1'b1;
      rd_a_addr = cur[SLOT_BITS-1:0];
    end
  end

  assign elem_rd_addr = (in_data.mode == MODE_READ) ? in_data.node_slot
                                                    : list_head[SLOT_BITS-1:0];

  // single link write port select
  always_comb begin
    wr_en   = 1'b0;
    elem_we = 1'b0;
    wr_addr = pw_addr;
    wr_data = pw_data;
    if (cmd.exec) begin
      if (do_push) begin
        wr_en   = 1'b1;
        elem_we = 1'b1;
        wr_addr = free_head[SLOT_BITS-1:0];
        wr_data = list_head;
      end else if (do_pop) begin
        wr_en   = 1'b1;
        wr_addr = list_head[SLOT_BITS-1:0];
        wr_data = free_head;
      end else if (do_ins) begin
        wr_en   = 1'b1;
        elem_we = 1'b1;
        wr_addr = free_head[SLOT_BITS-1:0];
        wr_data = link_b;
      end
    end else if (cmd.link_rd) begin
      wr_en   = 1'b1;
      wr_addr = req.node_slot;
      wr_data = link_a;
    end else if (cmd.wr2) begin
      wr_en   = 1'b1;
      wr_addr = pw_addr;
      wr_data = pw_free ? free_head : pw_data;
    end else if (cmd.walk_wr && flow.walk_more) begin
      wr_en   = 1'b1;
      wr_addr = cur[SLOT_BITS-1:0];
      wr_data = free_head;
    end
  end

  // link memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) link_mem[wr_addr] <= wr_data;
    if (rd_a_en) begin
      link_a_raw  <= link_mem[rd_a_addr];
      link_a_hit  <= link_vld[rd_a_addr];
      link_a_addr <= rd_a_addr;
    end
    if (cmd.accept) begin
      link_b_raw  <= link_mem[in_data.node_slot];
      link_b_hit  <= link_vld[in_data.node_slot];
      link_b_addr <= in_data.node_slot;
    end
  end

  // written flags for the link memory
  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (wr_en) begin
      link_vld[wr_addr] <= 1'b1;
    end
  end

  // element memory
  always_ff @(posedge clk) begin
    if (elem_we) elem_mem[free_head[SLOT_BITS-1:0]] <= req.element_value;
    if (cmd.accept) elem_rd <= elem_mem[elem_rd_addr];
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // head, free head and count
  always_ff @(posedge clk) begin
    if (rst) begin
      list_head  <= NULL_LINK;
      free_head  <= '0;
      list_count <= '0;
    end else if (cmd.exec) begin
      if (do_push) begin
        list_head  <= free_head;
        free_head  <= link_a;
        list_count <= list_count + COUNT_BITS'(1);
      end else if (do_pop) begin
        list_head  <= link_a;
        free_head  <= list_head;
        list_count <= list_count - COUNT_BITS'(1);
      end else if (do_ins) begin
        free_head  <= link_a;
        list_count <= list_count + COUNT_BITS'(1);
      end
    end else if (cmd.link_rd) begin
      list_count <= list_count - COUNT_BITS'(1);
    end else if (cmd.wr2) begin
      if (pw_free) free_head <= LINK_BITS'(pw_addr);
    end else if (cmd.walk_wr) begin
      if (flow.walk_more) begin
        free_head <= cur;
      end else begin
        list_head  <= NULL_LINK;
        list_count <= '0;
      end
    end
  end

  // request, pending write, walk cursor and result fields
  always_ff @(posedge clk) begin
    if (cmd.accept) req <= in_data;
    if (cmd.exec) begin
      res_status <= (do_era && t_null) ? STAT_NO_NEXT : stat;
      res_slot   <= (do_push || do_ins) ? free_head[SLOT_BITS-1:0] : '0;
      res_elem   <= (do_read || (do_pop && (req.mode == MODE_POP))) ? elem_rd : '0;
      if (do_ins) begin
        pw_addr <= req.node_slot;
        pw_data <= free_head;
        pw_free <= 1'b0;
      end else begin
        pw_addr <= link_a[SLOT_BITS-1:0];
        pw_data <= link_a;
        pw_free <= 1'b1;
      end
      cur    <= list_head;
      walk_n <= '0;
    end else if (cmd.walk_wr && flow.walk_more) begin
      cur    <= link_a;
      walk_n <= walk_n + COUNT_BITS'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.status         <= res_status;
      out_data.result_slot    <= res_slot;
      out_data.result_element <= res_elem;
      out_data.head_valid     <= !head_null;
      out_data.head_slot      <= head_null ? '0 : list_head[SLOT_BITS-1:0];
      out_data.node_count     <= list_count;
    end
  end

  // memory writes never overlap a request accept
  a_no_wr_on_accept: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !cmd.accept)
    else $error("link write coincides with request accept");

  // a push makes the old free head the new list head
  a_push_head: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && do_push) |=> (list_head == $past(free_head)))
    else $error("push did not move free head to list head");

  // the end of a clear walk leaves an empty list
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_wr && !flow.walk_more) |=> (list_count == '0) && (list_head == NULL_LINK))
    else $error("clear walk did not empty the list");

  // reported head matches the list state it was loaded from
  a_head_report: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (out_data.head_valid == (list_head != NULL_LINK)))
    else $error("reported head valid does not match list head");

endmodule

`default_nettype wire

>>> design/pooled_singly_linked_list_core.sv
// top level of the pooled singly linked list core
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_ready   in_data   (psll_in_t)
//   out      result     out_valid / out_ready out_data  (psll_out_t)
//   cfg      write      cfg_we                cfg_data  (capacity)
//
// each request runs an execute step and a done step; a successful insert after
// a node adds a second write, a successful erase after a node a link read and
// a second write, clear a walk write plus read per node freed (single write port).
// reset is synchronous; link written flags clear with it.
// a new request is taken while the previous result waits in the output register;
// a stalled output holds the core only when the next result is ready to load.
`default_nettype none

module pooled_singly_linked_list_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  psll_pkg::psll_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output psll_pkg::psll_out_t               out_data,
  input  logic                              cfg_we,
  input  logic [psll_pkg::COUNT_BITS-1:0]   cfg_data
);
  import psll_pkg::*;

  psll_cmd_t  cmd;
  psll_flow_t flow;

  // sequencing and handshakes
  psll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flow      (flow),
    .cmd       (cmd)
  );

  // memories and list state
  psll_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .flow     (flow),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
